// ===== src/tpfc_pkg.sv =====
package tpfc_pkg;

	localparam int unsigned SettingW  = 7;
	localparam int unsigned RepeatW   = 8;
	localparam int unsigned PulseW    = 4;
	localparam int unsigned ShiftW    = 16;
	localparam int unsigned BitIdxW   = 5;
	localparam int unsigned PaddrW    = 4;
	localparam int unsigned SettingCap = 99;
	localparam logic [BitIdxW-1:0] LatchIdx = 5'd16;

	localparam logic [1:0] RegMaxSetting  = 2'd0;
	localparam logic [1:0] RegRepeatTicks = 2'd1;
	localparam logic [1:0] RegPulseTicks  = 2'd2;

	localparam logic [SettingW-1:0] MaxSettingRst  = 7'd90;
	localparam logic [RepeatW-1:0]  RepeatTicksRst = 8'd50;
	localparam logic [PulseW-1:0]   PulseTicksRst  = 4'd2;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_DELAY = 2'd1,
		PH_PULSE = 2'd2
	} fire_phase_t;

	typedef struct packed {
		logic [SettingW-1:0] max_setting;
		logic [RepeatW-1:0]  repeat_ticks;
		logic [PulseW-1:0]   pulse_ticks;
	} cfg_t;

	typedef struct packed {
		logic                serial_data;
		logic                serial_clock;
		logic                latch;
		logic [SettingW-1:0] setting_now;
	} panel_out_t;

	function automatic logic [7:0] seg_code(input logic [3:0] d);
		logic [7:0] c;
		case (d)
			4'd0: c = 8'hC0;
			4'd1: c = 8'hF9;
			4'd2: c = 8'hA4;
			4'd3: c = 8'hB0;
			4'd4: c = 8'h99;
			4'd5: c = 8'h92;
			4'd6: c = 8'h82;
			4'd7: c = 8'hF8;
			4'd8: c = 8'h80;
			4'd9: c = 8'h90;
			default: c = 8'hFF;
		endcase
		return c;
	endfunction

	// Tens digit by multiplying with 205/2048, exact for every 7-bit value.
	function automatic logic [ShiftW-1:0] digits_code(input logic [SettingW-1:0] v);
		logic [14:0] prod;
		logic [3:0]  tens;
		logic [6:0]  tens10;
		logic [3:0]  units;
		prod   = 15'(v) * 15'd205;
		tens   = prod[14:11];
		tens10 = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
		units  = 4'(v - tens10);
		if (tens > 4'd9) begin
			tens = 4'd9;
		end
		return {seg_code(tens), seg_code(units)};
	endfunction

endpackage

// ===== src/tpfc_cfg.sv =====
module tpfc_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tpfc_pkg::PaddrW-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output tpfc_pkg::cfg_t                cfg
);
	import tpfc_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_setting  <= MaxSettingRst;
			cfg_q.repeat_ticks <= RepeatTicksRst;
			cfg_q.pulse_ticks  <= PulseTicksRst;
		end else if (wr_en) begin
			case (reg_idx)
				RegMaxSetting:  cfg_q.max_setting  <= pwdata[SettingW-1:0];
				RegRepeatTicks: cfg_q.repeat_ticks <= pwdata[RepeatW-1:0];
				RegPulseTicks:  cfg_q.pulse_ticks  <= pwdata[PulseW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			RegMaxSetting:  prdata = 32'(cfg_q.max_setting);
			RegRepeatTicks: prdata = 32'(cfg_q.repeat_ticks);
			RegPulseTicks:  prdata = 32'(cfg_q.pulse_ticks);
			default:        prdata = 32'd0;
		endcase
	end

endmodule

// ===== src/tpfc_fire.sv =====
module tpfc_fire (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            zero_cross,
	input  logic [tpfc_pkg::SettingW-1:0]   setting,
	input  logic [tpfc_pkg::PulseW-1:0]     pulse_ticks,
	output logic                            gate
);
	import tpfc_pkg::*;

	fire_phase_t         phase_q, phase_nxt;
	logic [SettingW-1:0] cnt_q, cnt_nxt, cnt_dec;
	logic                last_zc_q;
	logic [SettingW-1:0] plen;
	logic                edge_det;

	assign plen     = (pulse_ticks == '0) ? SettingW'(1) : SettingW'(pulse_ticks);
	assign edge_det = zero_cross && !last_zc_q;
	assign cnt_dec  = cnt_q - SettingW'(1);
	assign gate     = (phase_q == PH_PULSE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			cnt_q     <= '0;
			last_zc_q <= 1'b0;
		end else if (en) begin
			phase_q   <= phase_nxt;
			cnt_q     <= cnt_nxt;
			last_zc_q <= zero_cross;
		end
	end

	always_comb begin
		phase_nxt = PH_IDLE;
		cnt_nxt   = cnt_q;
		case (phase_q)
			PH_DELAY: begin
				cnt_nxt   = cnt_dec;
				phase_nxt = PH_DELAY;
				if (cnt_dec == '0) begin
					phase_nxt = PH_PULSE;
					cnt_nxt   = plen;
				end
			end
			PH_PULSE: begin
				cnt_nxt   = cnt_dec;
				phase_nxt = (cnt_dec == '0) ? PH_IDLE : PH_PULSE;
			end
			default: begin
				if (edge_det) begin
					if (setting == '0) begin
						phase_nxt = PH_PULSE;
						cnt_nxt   = plen;
					end else begin
						phase_nxt = PH_DELAY;
						cnt_nxt   = setting;
					end
				end
			end
		endcase
	end

endmodule

// ===== src/tpfc_panel.sv =====
module tpfc_panel (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            btn_down,
	input  logic                            btn_up,
	input  tpfc_pkg::cfg_t                  cfg,
	output logic [tpfc_pkg::SettingW-1:0]   setting,
	output tpfc_pkg::panel_out_t            pout
);
	import tpfc_pkg::*;

	logic [SettingW-1:0] setting_q, setting_nxt, limit;
	logic [RepeatW-1:0]  rep_q, rep_nxt, rep_len;
	logic [RepeatW:0]    rep_inc;
	logic [ShiftW-1:0]   shift_q, shift_nxt, shift_src;
	logic [BitIdxW-1:0]  bit_q, bit_nxt;

	assign setting = setting_q;
	assign limit   = (cfg.max_setting > SettingW'(SettingCap)) ? SettingW'(SettingCap)
		: cfg.max_setting;
	assign rep_len = (cfg.repeat_ticks == '0) ? RepeatW'(1) : cfg.repeat_ticks;
	assign rep_inc = {1'b0, rep_q} + (RepeatW+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setting_q <= '0;
			rep_q     <= '0;
			shift_q   <= '0;
			bit_q     <= '0;
		end else if (en) begin
			setting_q <= setting_nxt;
			rep_q     <= rep_nxt;
			shift_q   <= shift_nxt;
			bit_q     <= bit_nxt;
		end
	end

	always_comb begin
		setting_nxt = setting_q;
		rep_nxt     = '0;
		if (btn_down ^ btn_up) begin
			if (rep_inc >= {1'b0, rep_len}) begin
				if (btn_down) begin
					if (setting_q != '0) begin
						setting_nxt = setting_q - SettingW'(1);
					end
				end else if (setting_q < limit) begin
					setting_nxt = setting_q + SettingW'(1);
				end else begin
					setting_nxt = limit;
				end
			end else begin
				rep_nxt = rep_inc[RepeatW-1:0];
			end
		end
	end

	always_comb begin
		shift_src         = (bit_q == '0) ? digits_code(setting_nxt) : shift_q;
		shift_nxt         = shift_q;
		bit_nxt           = '0;
		pout.serial_data  = 1'b0;
		pout.serial_clock = 1'b0;
		pout.latch        = 1'b0;
		pout.setting_now  = setting_nxt;
		if (bit_q < LatchIdx) begin
			pout.serial_data  = shift_src[ShiftW-1];
			pout.serial_clock = 1'b1;
			shift_nxt         = {shift_src[ShiftW-2:0], 1'b0};
			bit_nxt           = bit_q + BitIdxW'(1);
		end else begin
			pout.latch = 1'b1;
		end
	end

endmodule

// ===== src/triac_phase_firing_controller.sv =====
// Channel  | Direction | Handshake          | Payload
// s_axis   | in        | s_tvalid/s_tready  | s_tdata: zero_cross, btn_down, btn_up
// m_axis   | out       | m_tvalid/m_tready  | m_tdata: gate, serial_data, serial_clock,
//          |           |                    |          latch, setting_now
// apb      | in        | psel/penable       | paddr, pwdata, prdata
//
// One item per cycle while m_tready is high; each passes the input, then the result register.
// An input register feeds one pass of logic that updates all counters and the result register.
// The output register lets a new item be taken while an earlier result waits for m_tready.
// Reset clears all control state and loads the register defaults.
module triac_phase_firing_controller (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [0] zero_cross, [1] btn_down, [2] btn_up
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [15:0]                   m_tdata,   // [0] gate, [1] serial_data,
	                                                 // [2] serial_clock, [3] latch,
	                                                 // [10:4] setting_now
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tpfc_pkg::PaddrW-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import tpfc_pkg::*;

	cfg_t                cfg;
	panel_out_t          pout;
	logic [SettingW-1:0] setting;
	logic                gate;
	logic                vld_s1, zc_s1, dn_s1, up_s1;
	logic                m_vld_q;
	logic [10:0]         res_q;
	logic                adv;

	assign adv      = vld_s1 && (!m_vld_q || m_tready);
	assign s_tready = !vld_s1 || adv;
	assign m_tvalid = m_vld_q;
	assign m_tdata  = {5'b0, res_q};

	tpfc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tpfc_fire u_fire (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (adv),
		.zero_cross  (zc_s1),
		.setting     (setting),
		.pulse_ticks (cfg.pulse_ticks),
		.gate        (gate)
	);

	tpfc_panel u_panel (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.btn_down (dn_s1),
		.btn_up   (up_s1),
		.cfg      (cfg),
		.setting  (setting),
		.pout     (pout)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			zc_s1 <= s_tdata[0];
			dn_s1 <= s_tdata[1];
			up_s1 <= s_tdata[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_vld_q <= 1'b0;
		end else if (adv) begin
			m_vld_q <= 1'b1;
		end else if (m_tready) begin
			m_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= {pout.setting_now, pout.latch, pout.serial_clock, pout.serial_data, gate};
		end
	end

endmodule

// ===== tb/triac_tick_checker.sv =====
module triac_tick_checker
	import tpfc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [7:0]        s_tdata,
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [15:0]       m_tdata,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [PaddrW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output int                mismatches,
	output int                outstanding,
	output int                compared
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic                gate;
		logic                sdata;
		logic                sclk;
		logic                lat;
		logic [SettingW-1:0] setting;
	} tick_result_t;

	logic [SettingW-1:0] cfg_max;
	logic [RepeatW-1:0]  cfg_repeat;
	logic [PulseW-1:0]   cfg_pulse;

	logic [SettingW-1:0] setting;
	logic                last_zc;
	fire_phase_t         phase;
	logic [SettingW-1:0] phase_cnt;
	logic [RepeatW-1:0]  repeat_cnt;
	logic [ShiftW-1:0]   shift_word;
	logic [BitIdxW-1:0]  bit_idx;

	tick_result_t panel_expected[$];
	tick_result_t want;
	tick_result_t got;
	tick_result_t fresh;

	initial begin
		mismatches = 0;
		outstanding = 0;
		compared = 0;
	end

	function automatic logic [7:0] segment_pattern(input int digit);
		logic [7:0] p;
		case (digit)
			0: p = 8'hC0;
			1: p = 8'hF9;
			2: p = 8'hA4;
			3: p = 8'hB0;
			4: p = 8'h99;
			5: p = 8'h92;
			6: p = 8'h82;
			7: p = 8'hF8;
			8: p = 8'h80;
			default: p = 8'h90;
		endcase
		return p;
	endfunction

	function automatic logic [ShiftW-1:0] display_word(input logic [SettingW-1:0] v);
		int tens;
		int units;
		tens = int'(v) / 10;
		units = int'(v) % 10;
		if (tens > 9) begin
			tens = 9;
		end
		return {segment_pattern(tens), segment_pattern(units)};
	endfunction

	task automatic advance_tick(input logic zc, input logic dn, input logic up,
		output tick_result_t r);
		logic [SettingW-1:0] limit;
		logic [RepeatW-1:0]  rep;
		logic [PulseW-1:0]   plen;
		logic                rising;
		logic [RepeatW:0]    next_cnt;
		limit = (cfg_max > SettingW'(SettingCap)) ? SettingW'(SettingCap) : cfg_max;
		rep = (cfg_repeat == '0) ? RepeatW'(1) : cfg_repeat;
		plen = (cfg_pulse == '0) ? PulseW'(1) : cfg_pulse;
		rising = zc && !last_zc;
		r = '0;
		r.gate = (phase == PH_PULSE);

		case (phase)
			PH_DELAY: begin
				phase_cnt = phase_cnt - 1'b1;
				if (phase_cnt == '0) begin
					phase = PH_PULSE;
					phase_cnt = SettingW'(plen);
				end
			end
			PH_PULSE: begin
				phase_cnt = phase_cnt - 1'b1;
				if (phase_cnt == '0) begin
					phase = PH_IDLE;
				end
			end
			default: begin
				phase = PH_IDLE;
				if (rising) begin
					if (setting == '0) begin
						phase = PH_PULSE;
						phase_cnt = SettingW'(plen);
					end else begin
						phase = PH_DELAY;
						phase_cnt = setting;
					end
				end
			end
		endcase
		last_zc = zc;

		if (dn ^ up) begin
			next_cnt = {1'b0, repeat_cnt} + 1'b1;
			if (next_cnt >= {1'b0, rep}) begin
				repeat_cnt = '0;
				if (dn) begin
					if (setting != '0) begin
						setting = setting - 1'b1;
					end
				end else if (setting < limit) begin
					setting = setting + 1'b1;
				end else begin
					setting = limit;
				end
			end else begin
				repeat_cnt = next_cnt[RepeatW-1:0];
			end
		end else begin
			repeat_cnt = '0;
		end

		if (bit_idx < LatchIdx) begin
			if (bit_idx == '0) begin
				shift_word = display_word(setting);
			end
			r.sdata = shift_word[ShiftW-1];
			r.sclk = 1'b1;
			shift_word = shift_word << 1;
			bit_idx = bit_idx + 1'b1;
		end else begin
			r.lat = 1'b1;
			bit_idx = '0;
		end
		r.setting = setting;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_max = MaxSettingRst;
			cfg_repeat = RepeatTicksRst;
			cfg_pulse = PulseTicksRst;
			setting = '0;
			last_zc = 1'b0;
			phase = PH_IDLE;
			phase_cnt = '0;
			repeat_cnt = '0;
			shift_word = '0;
			bit_idx = '0;
			panel_expected.delete();
			outstanding = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				compared++;
				got.gate = m_tdata[0];
				got.sdata = m_tdata[1];
				got.sclk = m_tdata[2];
				got.lat = m_tdata[3];
				got.setting = m_tdata[10:4];
				if (panel_expected.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: unexpected result, gate %0b data %0b clock %0b latch %0b setting %0d",
							$realtime, got.gate, got.sdata, got.sclk, got.lat, got.setting);
					end
				end else begin
					want = panel_expected.pop_front();
					if (want != got) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: result %0d expected gate %0b data %0b clock %0b latch %0b setting %0d",
								$realtime, compared, want.gate, want.sdata, want.sclk, want.lat,
								want.setting);
							$display("%0t: result %0d actual   gate %0b data %0b clock %0b latch %0b setting %0d",
								$realtime, compared, got.gate, got.sdata, got.sclk, got.lat,
								got.setting);
						end
					end
				end
			end

			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					RegMaxSetting:  cfg_max = pwdata[SettingW-1:0];
					RegRepeatTicks: cfg_repeat = pwdata[RepeatW-1:0];
					RegPulseTicks:  cfg_pulse = pwdata[PulseW-1:0];
					default: ;
				endcase
			end

			if (s_tvalid && s_tready) begin
				advance_tick(s_tdata[0], s_tdata[1], s_tdata[2], fresh);
				panel_expected.push_back(fresh);
			end
			outstanding = panel_expected.size();
		end
	end

endmodule

// ===== tb/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import tpfc_pkg::*;

	localparam int HoldCycles = 250;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [7:0]        s_tdata;
	logic              m_tvalid;
	logic              m_tready;
	logic [15:0]       m_tdata;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [PaddrW-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	int   mismatches;
	int   outstanding;
	int   compared;
	int   ticks_sent;
	int   settings_used;
	logic src_steady;
	logic sink_steady;
	logic hold_go;
	logic hold_off;

	triac_phase_firing_controller uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	triac_tick_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.compared    (compared)
	);

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	initial begin
		#1ms;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		hold_off = 1'b0;
		wait (hold_go);
		@(negedge clk);
		hold_off <= 1'b1;
		repeat (HoldCycles) @(negedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		int stall;
		m_tready = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			stall = sink_steady ? 0 : $urandom_range(0, 7);
			while (stall > 0 || hold_off) begin
				m_tready <= 1'b0;
				@(negedge clk);
				if (stall > 0) begin
					stall--;
				end
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	task automatic push_tick(input logic zc, input logic dn, input logic up);
		int gap;
		gap = src_steady ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'b00000, up, dn, zc};
		do @(posedge clk); while (!s_tready);
		ticks_sent++;
		@(negedge clk);
	endtask

	task automatic write_register(input logic [1:0] index, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	// Zero-cross as a square wave of random half periods, buttons held for random spans, with random noise ticks.
	task automatic mains_ticks(input int count, input int max_half, input int max_hold);
		logic       zc;
		logic       dn;
		logic       up;
		logic [2:0] noise;
		int         zc_left;
		int         btn_left;
		int         pick;
		zc = 1'b0;
		dn = 1'b0;
		up = 1'b0;
		zc_left = 1;
		btn_left = 1;
		for (int i = 0; i < count; i++) begin
			zc_left--;
			if (zc_left == 0) begin
				zc = !zc;
				zc_left = $urandom_range(1, max_half);
			end
			btn_left--;
			if (btn_left == 0) begin
				pick = $urandom_range(0, 9);
				dn = (pick == 7 || pick == 8 || pick == 9);
				up = (pick == 4 || pick == 5 || pick == 6 || pick == 9);
				btn_left = $urandom_range(1, max_hold);
			end
			if ($urandom_range(0, 9) == 0) begin
				noise = 3'($urandom);
				push_tick(noise[0], noise[1], noise[2]);
			end else begin
				push_tick(zc, dn, up);
			end
		end
	endtask

	task automatic run_phase(input logic [6:0] max_set, input logic [7:0] rep,
		input logic [3:0] plen, input int count, input int max_half, input int max_hold);
		wait_idle();
		write_register(RegMaxSetting, 32'(max_set));
		write_register(RegRepeatTicks, 32'(rep));
		write_register(RegPulseTicks, 32'(plen));
		settings_used++;
		mains_ticks(count, max_half, max_hold);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		ticks_sent = 0;
		settings_used = 1;
		src_steady = 1'b0;
		sink_steady = 1'b0;
		hold_go = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Default registers: firing at setting zero, an edge during the pulse, level held high.
		push_tick(1'b0, 1'b0, 1'b0);
		push_tick(1'b1, 1'b0, 1'b0);
		push_tick(1'b0, 1'b0, 1'b0);
		push_tick(1'b1, 1'b0, 1'b0);
		push_tick(1'b1, 1'b1, 1'b1);
		push_tick(1'b1, 1'b1, 1'b1);
		push_tick(1'b0, 1'b1, 1'b0);
		push_tick(1'b0, 1'b1, 1'b0);
		push_tick(1'b0, 1'b0, 1'b1);
		push_tick(1'b1, 1'b0, 1'b1);
		push_tick(1'b0, 1'b1, 1'b1);
		push_tick(1'b0, 1'b0, 1'b0);

		// Zero repeat and pulse registers, saturation at a low limit, then the limit lowered.
		wait_idle();
		write_register(RegMaxSetting, 32'd3);
		write_register(RegRepeatTicks, 32'd0);
		write_register(RegPulseTicks, 32'd0);
		settings_used++;
		repeat (5) push_tick(1'b0, 1'b0, 1'b1);
		push_tick(1'b1, 1'b0, 1'b0);
		repeat (4) push_tick(1'b0, 1'b0, 1'b0);
		wait_idle();
		write_register(RegMaxSetting, 32'd1);
		settings_used++;
		push_tick(1'b0, 1'b0, 1'b1);
		push_tick(1'b0, 1'b1, 1'b0);
		push_tick(1'b0, 1'b1, 1'b0);

		src_steady = 1'b1;
		fork
			begin
				repeat (20) @(negedge clk);
				hold_go = 1'b1;
			end
		join_none
		run_phase(7'd127, 8'd1, 4'd15, 90, 120, 120);
		src_steady = 1'b0;
		run_phase(7'd99, 8'd255, 4'd1, 50, 20, 60);
		run_phase(7'd0, 8'd1, 4'd0, 40, 10, 20);
		src_steady = 1'b1;
		sink_steady = 1'b1;
		run_phase(7'($urandom_range(0, 127)), 8'($urandom_range(1, 4)),
			4'($urandom_range(0, 15)), 70, 60, 80);
		src_steady = 1'b0;
		sink_steady = 1'b0;
		run_phase(7'($urandom_range(0, 127)), 8'($urandom_range(0, 3)),
			4'($urandom_range(0, 15)), 70, 40, 60);
		run_phase(7'd40, 8'd2, 4'd7, 70, 30, 50);

		wait_idle();
		repeat (10) @(negedge clk);
		$display("Sent %0d ticks under %0d register settings and compared %0d results.",
			ticks_sent, settings_used, compared);
		$display("Covered both setting limits, zero and clamped registers, ",
			"busy edges and a long output stall.");
		if (mismatches == 0 && outstanding == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
